[sv/ssr_pkg.sv]
// ---------------------------------------------------------------------------
// ssr_pkg
// Shared types, codes and the segment font for the serial refresh block.
// ---------------------------------------------------------------------------
package ssr_pkg;

	// number of digit positions that number writes fill
	localparam int DigitCount = 8;
	// digit position counter, holds 0 .. DigitCount
	localparam int PosW       = 4;

	localparam logic [7:0] SEG_MINUS = 8'h01;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	// digit segment store, entry p is sent at address p + 1
	typedef logic [7:0][7:0] seg_arr_t;

	// input word kinds carried on tuser
	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_RAW    = 3'd1,
		REQ_HEX    = 3'd2,
		REQ_HEXNUM = 3'd3,
		REQ_DEC    = 3'd4
	} req_kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_PERIOD = 3'd0,
		CFG_DECODE = 3'd1,
		CFG_INTENS = 3'd2,
		CFG_SCAN   = 3'd3,
		CFG_NORMAL = 3'd4,
		CFG_TEST   = 3'd5
	} cfg_idx_t;

	// commands from the controller
	typedef struct packed {
		logic step;
		logic wr_raw;
		logic wr_hex;
		logic wr_hexnum;
		logic load_dec;
		logic mul;
		logic dig;
		logic fill;
		logic done;
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		logic dig_last;
		logic fill_done;
	} sts_t;

	// line levels and pass count
	typedef struct packed {
		logic [15:0] pass;
		logic        sdata;
		logic        sclk;
		logic        cs;
	} pins_t;

	function automatic logic [7:0] hex_font(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'h7E;
			4'h1: s = 8'h30;
			4'h2: s = 8'h6D;
			4'h3: s = 8'h79;
			4'h4: s = 8'h33;
			4'h5: s = 8'h5B;
			4'h6: s = 8'h5F;
			4'h7: s = 8'h70;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h7B;
			4'hA: s = 8'h77;
			4'hB: s = 8'h1F;
			4'hC: s = 8'h0D;
			4'hD: s = 8'h3D;
			4'hE: s = 8'h4F;
			4'hF: s = 8'h47;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

[sv/ssr_ctrl.sv]
// ---------------------------------------------------------------------------
// ssr_ctrl
// Item controller: input handshake, decimal formatting sequence, output valid.
// ---------------------------------------------------------------------------
module ssr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2:0]          kind,
	input  logic                m_tready,
	output logic                m_tvalid,
	input  ssr_pkg::sts_t       sts,
	output ssr_pkg::cmd_t       cmd
);
	import ssr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DMUL = 4'b0010,
		ST_DDIG = 4'b0100,
		ST_FILL = 4'b1000
	} st_t;

	st_t  state_q, state_d;
	logic accept;
	logic m_tvalid_q;

	// take a word only when idle and the output register is free
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_kind_t'(kind))
						REQ_TICK: begin
							cmd.step = 1'b1;
							cmd.done = 1'b1;
						end
						REQ_RAW: begin
							cmd.wr_raw = 1'b1;
							cmd.done   = 1'b1;
						end
						REQ_HEX: begin
							cmd.wr_hex = 1'b1;
							cmd.done   = 1'b1;
						end
						REQ_HEXNUM: begin
							cmd.wr_hexnum = 1'b1;
							cmd.done      = 1'b1;
						end
						REQ_DEC: begin
							cmd.load_dec = 1'b1;
							state_d      = ST_DMUL;
						end
						default: cmd.done = 1'b1;
					endcase
				end
			end
			ST_DMUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DDIG;
			end
			ST_DDIG: begin
				cmd.dig = 1'b1;
				state_d = sts.dig_last ? ST_FILL : ST_DMUL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_done) begin
					cmd.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.done)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

[sv/ssr_digits.sv]
// ---------------------------------------------------------------------------
// ssr_digits
// Digit segment store with raw, hex and decimal writers; the decimal writer
// divides by ten with a reciprocal multiply, one digit per multiply and digit step.
// ---------------------------------------------------------------------------
module ssr_digits (
	input  logic               clk,
	input  logic               arst_n,
	input  ssr_pkg::cmd_t      cmd,
	input  logic [2:0]         position,
	input  logic [31:0]        value,
	input  logic               zero_fill,
	output ssr_pkg::sts_t      sts,
	output ssr_pkg::seg_arr_t  digits
);
	import ssr_pkg::*;

	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	seg_arr_t        seg_q;
	logic [31:0]     mag_q;
	logic [28:0]     prod_q;
	logic [PosW-1:0] pos_q;
	logic            neg_q;
	logic            zf_q;
	logic [63:0]     prod_full;
	logic [31:0]     q_ext;
	logic [31:0]     q_times10;
	logic [31:0]     rem_full;
	logic [3:0]      rem;

	assign digits = seg_q;

	// quotient and remainder of the current magnitude by ten
	assign prod_full = mag_q * RECIP10;
	assign q_ext     = {3'b000, prod_q};
	assign q_times10 = (q_ext << 3) + (q_ext << 1);
	assign rem_full  = mag_q - q_times10;
	assign rem       = rem_full[3:0];

	assign sts.dig_last  = (pos_q == PosW'(DigitCount - 1)) || (!zf_q && (prod_q == '0));
	assign sts.fill_done = (pos_q == PosW'(DigitCount));

	// decimal working registers
	always_ff @(posedge clk) begin
		if (cmd.load_dec) begin
			mag_q <= value[31] ? (32'd0 - value) : value;
			neg_q <= value[31];
			zf_q  <= zero_fill;
			pos_q <= '0;
		end
		if (cmd.mul)
			prod_q <= prod_full[63:35];
		if (cmd.dig) begin
			mag_q <= q_ext;
			pos_q <= pos_q + PosW'(1);
		end
		if (cmd.fill && !sts.fill_done) begin
			neg_q <= 1'b0;
			pos_q <= pos_q + PosW'(1);
		end
	end

	// segment store writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else begin
			if (cmd.wr_raw)
				seg_q[position] <= value[7:0];
			if (cmd.wr_hex)
				seg_q[position] <= hex_font(value[3:0]);
			if (cmd.wr_hexnum) begin
				for (int i = 0; i < DigitCount; i++)
					seg_q[i] <= hex_font(value[4*i +: 4]);
			end
			if (cmd.dig)
				seg_q[pos_q[2:0]] <= hex_font(rem);
			if (cmd.fill && !sts.fill_done)
				seg_q[pos_q[2:0]] <= neg_q ? SEG_MINUS : SEG_BLANK;
		end
	end

endmodule

[sv/ssr_shifter.sv]
// ---------------------------------------------------------------------------
// ssr_shifter
// Control settings and the bit-timing sequencer that shifts address/data
// words out on select, clock and data lines, one step per tick.
// ---------------------------------------------------------------------------
module ssr_shifter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               step,
	input  ssr_pkg::seg_arr_t  digits,
	output ssr_pkg::pins_t     pins,
	output ssr_pkg::pins_t     pins_nxt
);
	import ssr_pkg::*;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_START = 8'b0000_0010,
		PH_LEAD  = 8'b0000_0100,
		PH_SETUP = 8'b0000_1000,
		PH_RISE  = 8'b0001_0000,
		PH_END   = 8'b0010_0000,
		PH_TAIL  = 8'b0100_0000,
		PH_HOLD  = 8'b1000_0000
	} phase_t;

	localparam logic [3:0] ADDR_DECODE = 4'd9;
	localparam logic [3:0] ADDR_INTENS = 4'd10;
	localparam logic [3:0] ADDR_SCAN   = 4'd11;
	localparam logic [3:0] ADDR_NORMAL = 4'd12;
	localparam logic [3:0] ADDR_TEST   = 4'd15;

	logic [15:0] period_q;
	logic [7:0]  decode_q;
	logic [3:0]  intens_q;
	logic [2:0]  scan_q;
	logic        normal_q;
	logic        test_q;

	phase_t      phase_q, phase_d;
	logic [4:0]  bit_q, bit_d;
	logic [3:0]  ridx_q, ridx_d;
	logic [15:0] word_q, word_d;
	logic [15:0] start_q, start_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] pass_q, pass_d;
	logic        cs_q, cs_d, sclk_q, sclk_d, sdata_q, sdata_d;

	logic [15:0] half;
	logic [15:0] elapsed;
	logic [4:0]  idx_inc;
	logic [3:0]  next_idx;
	logic        next_wrap;
	logic [3:0]  idx_m1;
	logic [7:0]  next_data;
	logic [4:0]  bit_inc;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 16'd16;
			decode_q <= 8'd0;
			intens_q <= 4'd8;
			scan_q   <= 3'd7;
			normal_q <= 1'b1;
			test_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD: period_q <= cfg_data;
				CFG_DECODE: decode_q <= cfg_data[7:0];
				CFG_INTENS: intens_q <= cfg_data[3:0];
				CFG_SCAN:   scan_q   <= cfg_data[2:0];
				CFG_NORMAL: normal_q <= cfg_data[0];
				CFG_TEST:   test_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next register address: 13 and 14 skipped, wrap after 15 to 1
	always_comb begin
		idx_inc   = {1'b0, ridx_q} + 5'd1;
		next_wrap = 1'b0;
		if (idx_inc == 5'd13)
			idx_inc = 5'd15;
		if (idx_inc[4]) begin
			idx_inc   = 5'd1;
			next_wrap = 1'b1;
		end
		next_idx = idx_inc[3:0];
	end

	// data byte for that address
	assign idx_m1 = next_idx - 4'd1;
	always_comb begin
		if (next_idx inside {[4'd1:4'd8]}) begin
			next_data = digits[idx_m1[2:0]];
		end else begin
			case (next_idx)
				ADDR_DECODE: next_data = decode_q;
				ADDR_INTENS: next_data = {4'd0, intens_q};
				ADDR_SCAN:   next_data = {5'd0, scan_q};
				ADDR_NORMAL: next_data = {7'd0, normal_q};
				ADDR_TEST:   next_data = {7'd0, test_q};
				default:     next_data = 8'd0;
			endcase
		end
	end

	assign half    = period_q >> 1;
	assign elapsed = tick_d - start_q;
	assign bit_inc = bit_q + 5'd1;

	// sequencer step
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		ridx_d  = ridx_q;
		word_d  = word_q;
		start_d = start_q;
		tick_d  = tick_q;
		pass_d  = pass_q;
		cs_d    = cs_q;
		sclk_d  = sclk_q;
		sdata_d = sdata_q;
		if (step) begin
			tick_d = tick_q + 16'd1;
			case (phase_q)
				PH_IDLE: begin
					ridx_d  = next_idx;
					word_d  = {4'd0, next_idx, next_data};
					if (next_wrap)
						pass_d = pass_q + 16'd1;
					phase_d = PH_START;
				end
				PH_START: begin
					cs_d    = 1'b0;
					sclk_d  = 1'b0;
					sdata_d = 1'b0;
					bit_d   = 5'd0;
					start_d = tick_d;
					phase_d = PH_LEAD;
				end
				PH_LEAD: begin
					if (elapsed >= period_q)
						phase_d = PH_SETUP;
				end
				PH_SETUP: begin
					sdata_d = word_q[4'd15 - bit_q[3:0]];
					sclk_d  = 1'b0;
					start_d = tick_d;
					phase_d = PH_RISE;
				end
				PH_RISE: begin
					if (elapsed >= half) begin
						sclk_d  = 1'b1;
						phase_d = PH_END;
					end
				end
				PH_END: begin
					if (elapsed >= period_q) begin
						bit_d = bit_inc;
						if (bit_inc[4]) begin
							sclk_d  = 1'b0;
							start_d = tick_d;
							phase_d = PH_TAIL;
						end else begin
							phase_d = PH_SETUP;
						end
					end
				end
				PH_TAIL: begin
					if (elapsed >= half) begin
						cs_d    = 1'b1;
						start_d = tick_d;
						phase_d = PH_HOLD;
					end
				end
				PH_HOLD: begin
					if (elapsed >= half)
						phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			ridx_q  <= '0;
			word_q  <= '0;
			start_q <= '0;
			tick_q  <= '0;
			pass_q  <= '0;
			cs_q    <= 1'b1;
			sclk_q  <= 1'b0;
			sdata_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			ridx_q  <= ridx_d;
			word_q  <= word_d;
			start_q <= start_d;
			tick_q  <= tick_d;
			pass_q  <= pass_d;
			cs_q    <= cs_d;
			sclk_q  <= sclk_d;
			sdata_q <= sdata_d;
		end
	end

	assign pins     = '{pass: pass_q, sdata: sdata_q, sclk: sclk_q, cs: cs_q};
	assign pins_nxt = '{pass: pass_d, sdata: sdata_d, sclk: sclk_d, cs: cs_d};

endmodule

[sv/seven_segment_serial_refresh.sv]
// ---------------------------------------------------------------------------
// seven_segment_serial_refresh
// Tick, raw, hex digit and hex number words: result in the cycle after accept,
// one word per cycle while the result side takes them.
// Decimal words: a multiply step and a digit step per digit in the shared
// divide-by-ten multiplier, then the blanking sweep; one word at a time.
// Reset (arst_n, asynchronous): all settings, digits and the sequencer go to
// their defaults at once; no clearing pass.
// ---------------------------------------------------------------------------
module seven_segment_serial_refresh (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[2:0], value[34:3], zero_fill[35]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // chip_select[0], serial_clock[1], serial_data[2],
	                               // refresh_count[18:3]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ssr_pkg::*;

	cmd_t     cmd;
	sts_t     sts;
	seg_arr_t digits;
	pins_t    pins;
	pins_t    pins_nxt;
	pins_t    out_q;

	ssr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssr_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.position  (s_tdata[2:0]),
		.value     (s_tdata[34:3]),
		.zero_fill (s_tdata[35]),
		.sts       (sts),
		.digits    (digits)
	);

	ssr_shifter u_shifter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (cmd.step),
		.digits    (digits),
		.pins      (pins),
		.pins_nxt  (pins_nxt)
	);

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.done)
			out_q <= pins_nxt;
	end

	assign m_tdata = {5'd0, out_q.pass, out_q.sdata, out_q.sclk, out_q.cs};

	// a finished non-decimal word shows on the output next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser != REQ_DEC)) |=> m_tvalid)
		else $error("result word missing after a single-cycle word");

	// no new word while a result is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result register is full");

	// select is released only with the clock line low
	a_cs_release: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pins.cs) |-> !pins.sclk)
		else $error("chip select released with clock high");

endmodule
